// ===== rtl/msf_pkg.sv =====
// Shared types, constants and the sigmoid table for the perceptron block.
package msf_pkg;

  localparam int unsigned MaxNeurons = 64;
  localparam int unsigned MaxLayers  = 4;
  localparam int unsigned WidthRegs  = 4;
  localparam int unsigned RegCount   = 6;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    ActWeight = 2'd0,
    ActBias   = 2'd1,
    ActInput  = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RegLayers = 3'd0,
    RegWidth0 = 3'd1,
    RegWidth1 = 3'd2,
    RegWidth2 = 3'd3,
    RegWidth3 = 3'd4,
    RegWidth4 = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StBias,
    StMac,
    StDrain,
    StFinish,
    StEmit
  } back_state_e;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    action_e     action;
    logic [1:0]  layer;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
    logic        last;
  } cmd_t;

  function automatic logic [8:0] sig_lut(input logic [5:0] t);
    logic [8:0] s;
    unique case (t)
      6'd0: s = 9'd128;  6'd1: s = 9'd136;  6'd2: s = 9'd144;  6'd3: s = 9'd152;
      6'd4: s = 9'd159;  6'd5: s = 9'd167;  6'd6: s = 9'd174;  6'd7: s = 9'd181;
      6'd8: s = 9'd187;  6'd9: s = 9'd193;  6'd10: s = 9'd199; 6'd11: s = 9'd204;
      6'd12: s = 9'd209; 6'd13: s = 9'd214; 6'd14: s = 9'd218; 6'd15: s = 9'd222;
      6'd16: s = 9'd225; 6'd17: s = 9'd229; 6'd18: s = 9'd232; 6'd19: s = 9'd234;
      6'd20: s = 9'd237; 6'd21: s = 9'd239; 6'd22: s = 9'd241; 6'd23: s = 9'd242;
      6'd24: s = 9'd244; 6'd25: s = 9'd245; 6'd26: s = 9'd246; 6'd27: s = 9'd248;
      6'd28: s = 9'd248; 6'd29: s = 9'd249; 6'd30: s = 9'd250; 6'd31: s = 9'd251;
      6'd32: s = 9'd251; 6'd33: s = 9'd252; 6'd34: s = 9'd252; 6'd35: s = 9'd253;
      6'd36: s = 9'd253; 6'd37: s = 9'd254; 6'd38: s = 9'd254; 6'd39: s = 9'd254;
      6'd40: s = 9'd254; 6'd41: s = 9'd254; 6'd42: s = 9'd255; 6'd43: s = 9'd255;
      6'd44: s = 9'd255; 6'd45: s = 9'd255; 6'd46: s = 9'd255; 6'd47: s = 9'd255;
      6'd48: s = 9'd255; 6'd49: s = 9'd255;
      default: s = 9'd256;
    endcase
    return s;
  endfunction

  // Q8.8 value into Q1.8 sigmoid, symmetric around zero.
  function automatic logic [8:0] sigmoid_q(input logic signed [15:0] z);
    logic [15:0] mag;
    logic [10:0] t;
    logic [8:0]  s;
    mag = z[15] ? 16'(-z) : z;
    t   = mag[15:5];
    s   = (t < 11'd64) ? sig_lut(t[5:0]) : 9'd256;
    return z[15] ? 9'(9'd256 - s) : s;
  endfunction

endpackage

// ===== rtl/mlp_sigmoid_forward.sv =====
// Top level of the sigmoid perceptron inference block.
//  channel | signals                                   | direction
//  cmd     | start_i/busy_o, action..last_input        | in
//  result  | result_valid_o, out_index..last_output    | out
//  config  | cfg_we_i, cfg_index_i, cfg_data_i         | in
// Loads are written to the stores while the back end is idle. A pass runs each layer
// through the single multiplier walking the weight memory, then emits the last layer.
// Reset clears the registers to 1 and empties the queue; the stores hold garbage.
// busy_o rises only when the four-beat command queue is full.
module mlp_sigmoid_forward #(
  parameter int unsigned MaxNeur = msf_pkg::MaxNeurons,
  parameter int unsigned MaxLay  = msf_pkg::MaxLayers
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  layer_sel_i,
  input  logic [5:0]  row_index_i,
  input  logic [5:0]  col_index_i,
  input  logic [15:0] value_i,
  input  logic        last_input_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [5:0]  out_index_o,
  output logic [8:0]  activation_o,
  output logic        last_output_o
);
  import msf_pkg::*;

  logic [2:0]              layers_q;
  logic [WidthRegs:0][6:0] width_q;
  logic                    cmd_valid, cmd_pop, done;
  cmd_t                    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layers_q <= 3'd1;
      width_q  <= {(WidthRegs+1){7'd1}};
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        RegLayers: layers_q <= cfg_data_i[2:0];
        RegWidth0: width_q[0] <= cfg_data_i;
        RegWidth1: width_q[1] <= cfg_data_i;
        RegWidth2: width_q[2] <= cfg_data_i;
        RegWidth3: width_q[3] <= cfg_data_i;
        RegWidth4: width_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  msf_front #(.MaxNeur(MaxNeur), .MaxLay(MaxLay)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .layer_sel_i, .row_index_i,
    .col_index_i, .value_i, .last_input_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop));

  msf_back #(.MaxNeur(MaxNeur), .MaxLay(MaxLay)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .cfg_layers_i(layers_q), .cfg_width_i(width_q), .done_o(done),
    .out_index_o, .activation_o, .last_output_o);

  assign result_valid_o = done;
endmodule

// ===== rtl/msf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module msf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/msf_front.sv =====
// Front end: accepts command beats, drops out-of-range ones and queues the rest.
module msf_front #(
  parameter int unsigned MaxNeur = msf_pkg::MaxNeurons,
  parameter int unsigned MaxLay  = msf_pkg::MaxLayers
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    action_i,
  input  logic [1:0]    layer_sel_i,
  input  logic [5:0]    row_index_i,
  input  logic [5:0]    col_index_i,
  input  logic [15:0]   value_i,
  input  logic          last_input_i,
  output logic          cmd_valid_o,
  output msf_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import msf_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t          fifo_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic          accept, keep, in_range;

  always_comb begin
    unique case (action_e'(action_i))
      ActWeight: in_range = 32'(layer_sel_i) < MaxLay && 32'(row_index_i) < MaxNeur
                            && 32'(col_index_i) < MaxNeur;
      ActBias:   in_range = 32'(layer_sel_i) < MaxLay && 32'(row_index_i) < MaxNeur;
      ActInput:  in_range = 1'b1;
      default:   in_range = 1'b0;
    endcase
  end

  // Only a full queue holds the sender off; during a pass the queue fills up.
  assign busy_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign accept  = start_i && !busy_o;
  assign keep    = accept && in_range;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o   = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (keep) begin
      fifo_q[wr_q].action <= action_e'(action_i);
      fifo_q[wr_q].layer  <= layer_sel_i;
      fifo_q[wr_q].row    <= row_index_i;
      fifo_q[wr_q].col    <= col_index_i;
      fifo_q[wr_q].value  <= value_i;
      fifo_q[wr_q].last   <= last_input_i && (action_e'(action_i) == ActInput)
                             && (32'(col_index_i) < MaxNeur);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (keep) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(keep) - (PtrW+1)'(cmd_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_i |-> cmd_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (keep && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

// ===== rtl/msf_back.sv =====
// Back end: writes the stores and runs the layer-by-layer forward pass.
module msf_back #(
  parameter int unsigned MaxNeur = msf_pkg::MaxNeurons,
  parameter int unsigned MaxLay  = msf_pkg::MaxLayers
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  msf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic [2:0]    cfg_layers_i,
  input  logic [msf_pkg::WidthRegs:0][6:0] cfg_width_i,
  output logic          done_o,
  output logic [5:0]    out_index_o,
  output logic [8:0]    activation_o,
  output logic          last_output_o
);
  import msf_pkg::*;

  localparam int unsigned NW  = $clog2(MaxNeur);
  localparam int unsigned LW  = (MaxLay > 1) ? $clog2(MaxLay) : 1;
  localparam int unsigned WAW = LW + 2 * NW;
  localparam int unsigned BAW = LW + NW;
  localparam int unsigned AAW = 1 + NW;
  localparam int unsigned LimL = (MaxLay < WidthRegs) ? MaxLay : WidthRegs;

  back_state_e     state_q, state_d;
  logic [LW-1:0]   lay_q, lay_d;
  logic            cur_q, cur_d;
  logic [NW:0]     row_q, row_d, col_q, col_d;
  logic            rd_v_q, rd_v_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [31:0] prod_q;
  logic            prod_v_q;
  logic [2:0]      nlay;
  logic [NW:0]     src_w, dst_w;

  logic            w_we, b_we, a_we;
  logic [WAW-1:0]  w_wa, w_ra;
  logic [BAW-1:0]  b_wa, b_ra;
  logic [AAW-1:0]  a_wa, a_ra;
  logic [15:0]     w_rd, b_rd, a_rd, a_wd;

  function automatic logic [NW:0] eff_w(input logic [6:0] w);
    logic [NW:0] r;
    if (w == '0) r = (NW+1)'(1);
    else if (32'(w) > MaxNeur) r = (NW+1)'(MaxNeur);
    else r = (NW+1)'(w);
    return r;
  endfunction

  always_comb begin
    nlay = cfg_layers_i;
    if (nlay == '0) nlay = 3'd1;
    if (32'(nlay) > LimL) nlay = 3'(LimL);
    src_w = eff_w(cfg_width_i[lay_q]);
    dst_w = eff_w(cfg_width_i[32'(lay_q) + 1]);
  end

  msf_ram #(.Width(16), .Depth(MaxLay * MaxNeur * MaxNeur)) u_wram (
    .clk_i, .we_i(w_we), .waddr_i(w_wa), .wdata_i(cmd_i.value),
    .raddr_i(w_ra), .rdata_o(w_rd));
  msf_ram #(.Width(16), .Depth(MaxLay * MaxNeur)) u_bram (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(cmd_i.value),
    .raddr_i(b_ra), .rdata_o(b_rd));
  msf_ram #(.Width(16), .Depth(2 * MaxNeur)) u_aram (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd),
    .raddr_i(a_ra), .rdata_o(a_rd));

  logic signed [47:0] q_full;
  logic signed [15:0] z_sat;
  logic [NW-1:0]      out_row;

  always_comb begin
    q_full = acc_q >>> 8;
    if (q_full > 48'sd32767) z_sat = 16'sh7fff;
    else if (q_full < -48'sd32768) z_sat = 16'sh8000;
    else z_sat = q_full[15:0];
  end

  assign out_row = row_q[NW-1:0];
  assign w_ra = {lay_q, out_row, col_q[NW-1:0]};
  assign b_ra = {lay_q, out_row};

  always_comb begin
    state_d   = state_q;
    lay_d     = lay_q;
    cur_d     = cur_q;
    row_d     = row_q;
    col_d     = col_q;
    rd_v_d    = 1'b0;
    acc_d     = acc_q;
    cmd_pop_o = 1'b0;
    w_we = 1'b0; b_we = 1'b0; a_we = 1'b0;
    w_wa = {cmd_i.layer[LW-1:0], cmd_i.row[NW-1:0], cmd_i.col[NW-1:0]};
    b_wa = {cmd_i.layer[LW-1:0], cmd_i.row[NW-1:0]};
    a_wa = {1'b0, cmd_i.col[NW-1:0]};
    a_wd = cmd_i.value;
    a_ra = {cur_q, col_q[NW-1:0]};
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.action)
            ActWeight: w_we = 1'b1;
            ActBias:   b_we = 1'b1;
            ActInput:  a_we = 1'b1;
            default: ;
          endcase
          if (cmd_i.last) begin
            state_d = StBias; lay_d = '0; cur_d = 1'b0; row_d = '0;
          end
        end
      end
      // Bias read goes out; first operand reads start next.
      StBias: begin
        col_d = '0;
        state_d = StMac;
      end
      StMac: begin
        if (col_q == '0 && !prod_v_q && !rd_v_q) acc_d = 48'(signed'(b_rd)) <<< 8;
        rd_v_d = 1'b1;
        if (col_q + 1'b1 == src_w) state_d = StDrain;
        col_d = col_q + 1'b1;
      end
      StDrain: begin
        if (!rd_v_q && !prod_v_q) state_d = StFinish;
      end
      StFinish: begin
        a_we = 1'b1;
        a_wa = {~cur_q, out_row};
        a_wd = 16'(sigmoid_q(z_sat));
        if (row_q + 1'b1 == dst_w) begin
          row_d = '0;
          cur_d = ~cur_q;
          if (32'(lay_q) + 1 == 32'(nlay)) state_d = StEmit;
          else begin
            lay_d = lay_q + 1'b1; state_d = StBias;
          end
        end else begin
          row_d = row_q + 1'b1; state_d = StBias;
        end
      end
      // The final layer stays selected, so its width is dst_w.
      StEmit: begin
        a_ra = {cur_q, out_row};
        rd_v_d = 1'b1;
        if (row_q + 1'b1 == dst_w) state_d = StIdle;
        else row_d = row_q + 1'b1;
      end
      default: state_d = StIdle;
    endcase
    if (prod_v_q) acc_d = acc_d + 48'(prod_q);
  end

  // Emit results from the registered activation read of the previous cycle.
  logic            emit_q;
  logic [NW-1:0]   eidx_q;
  logic            elast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      lay_q    <= '0;
      cur_q    <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      emit_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      lay_q    <= lay_d;
      cur_q    <= cur_d;
      row_q    <= row_d;
      col_q    <= col_d;
      rd_v_q   <= rd_v_d && state_q == StMac;
      prod_v_q <= rd_v_q;
      emit_q   <= state_q == StEmit;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= signed'(w_rd) * signed'(a_rd);
    eidx_q  <= out_row;
    elast_q <= state_q == StEmit && row_q + 1'b1 == dst_w;
  end

  assign done_o        = emit_q;
  assign out_index_o   = 6'(eidx_q);
  assign activation_o  = a_rd[8:0];
  assign last_output_o = elast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == StIdle) else $error("pop during pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> $past(rd_v_q)) else $error("product without read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |-> !prod_v_q && !rd_v_q) else $error("finish with MAC in flight");
endmodule
